@@ rtl/scanner_telegram_receiver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the scanner telegram receiver
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SCANNER_TELEGRAM_RECEIVER_UNIT_DEFINES_SVH
`define SCANNER_TELEGRAM_RECEIVER_UNIT_DEFINES_SVH

// Check a property outside reset
`define STU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included
`define STU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/stu_pkg.sv @@
// ----------------------------------------------------------------------------
// Scanner telegram receiver package
// Widths, codes, reset values and word layouts shared by the design.
// ----------------------------------------------------------------------------
package stu_pkg;

  // Store depth default
  localparam int unsigned BUF_DEPTH_DEF = 1024;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned TOTAL_W = 17;

  // Stream word widths (whole bytes)
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LIMIT_W;

  // Telegram framing
  localparam int unsigned HDR_CRC_BYTES = 6;
  localparam int unsigned MIN_LIMIT     = 6;
  // Fill counts at which header bytes are complete
  localparam int unsigned POS_START  = 1;
  localparam int unsigned POS_ADDR   = 2;
  localparam int unsigned POS_LEN_LO = 3;
  localparam int unsigned POS_LEN_HI = 4;

  // Register reset values
  localparam logic [BYTE_W-1:0]  START_RESET = 8'd2;
  localparam logic [BYTE_W-1:0]  ADDR_RESET  = 8'd128;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX      = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START   = 2'd0,
    CFG_ADDRESS = 2'd1,
    CFG_LIMIT   = 2'd2
  } cfg_idx_e;

  // Status of one word while its store read is in flight
  typedef struct packed {
    logic               index_valid;
    logic               frame_ready;
    logic               buffer_full;
    logic [TOTAL_W-1:0] total_length;
    logic               byte_dropped;
    logic               release_ok;
  } stat_t;

endpackage

@@ rtl/stu_frame_store.sv @@
// ----------------------------------------------------------------------------
// Telegram byte store
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module stu_frame_store import stu_pkg::*; #(
  parameter int unsigned DEPTH = BUF_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [BYTE_W-1:0]          wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [BYTE_W-1:0]          rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/scanner_telegram_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// Scanner telegram receiver
// Assembles start/address/length/payload/CRC telegrams from received bytes
// in a byte store, serves indexed reads and releases the store on request.
//
//   channel   dir  handshake                  content
//   s_axis    in   s_axis_tvalid/tready       tuser: command; tdata: byte, index, length
//   m_axis    out  m_axis_tvalid/tready       tdata: read data and status
//   cfg       in   cfg_we_i                   start byte, address byte, buffer limit
//
// One word per cycle while m_axis_tready_i is high; a result passes through the read
// stage, beside the registered store read, and then through the output register.
// Reset clears counters and flags at once; the store needs no clearing pass.
// A low m_axis_tready holds the output register and the read stage; input
// words are still taken while the read stage is empty.
// ----------------------------------------------------------------------------
`include "scanner_telegram_receiver_unit_defines.svh"

module scanner_telegram_receiver_unit import stu_pkg::*; #(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] rx_byte, [17:8] read_index, [33:18] request_length, [39:34] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  // Output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] read_data, [8] index_valid, [9] frame_ready, [10] buffer_full,
  // [27:11] frame_total_length, [28] byte_dropped, [29] release_ok, [31:30] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(BUF_DEPTH);
  localparam int unsigned CntW  = $clog2(BUF_DEPTH + 1);

  // Input fields
  cmd_e              cmd;
  logic [BYTE_W-1:0] rx_byte;
  logic [IDX_W-1:0]  read_index;
  logic [REQ_W-1:0]  request_length;

  assign cmd            = cmd_e'(s_axis_tuser_i);
  assign rx_byte        = s_axis_tdata_i[7:0];
  assign read_index     = s_axis_tdata_i[17:8];
  assign request_length = s_axis_tdata_i[33:18];

  // Configuration registers
  logic [BYTE_W-1:0]  start_q, addr_q;
  logic [LIMIT_W-1:0] limit_q;

  // Frame state
  logic [CntW-1:0]   fill_q, fill_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ready_q, ready_d;
  logic              full_q, full_d;
  logic [BYTE_W-1:0] byte0_q, byte0_d;
  logic [BYTE_W-1:0] lenlo_q, lenlo_d;

  // Pipeline
  logic              s1_valid_q;
  stat_t             s1_q;
  stat_t             stat;
  logic              out_valid_q;
  logic [M_TDATA_W-1:0] out_q;
  logic              s1_adv, in_ready, in_acc;

  // Store access
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic [TOTAL_W-1:0] total, total_nxt, fill_inc, eff_limit, lim_ext;

  // Handshake: the read stage moves on when the output register is free
  assign s1_adv   = !out_valid_q || m_axis_tready_i;
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_acc   = s_axis_tvalid_i && in_ready;

  // Clamp the buffer limit into its legal range
  always_comb begin
    lim_ext   = TOTAL_W'(limit_q);
    eff_limit = lim_ext;
    if (lim_ext < TOTAL_W'(MIN_LIMIT)) begin
      eff_limit = TOTAL_W'(MIN_LIMIT);
    end
    if (lim_ext > TOTAL_W'(BUF_DEPTH)) begin
      eff_limit = TOTAL_W'(BUF_DEPTH);
    end
  end

  assign total    = TOTAL_W'(len_q) + TOTAL_W'(HDR_CRC_BYTES);
  assign fill_inc = TOTAL_W'(fill_q) + TOTAL_W'(1);

  // Command decode and frame state update
  always_comb begin
    fill_d    = fill_q;
    len_d     = len_q;
    ready_d   = ready_q;
    full_d    = full_q;
    byte0_d   = byte0_q;
    lenlo_d   = lenlo_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = fill_q[AddrW-1:0];
    stat      = '0;
    if (in_acc) begin
      case (cmd)
        CMD_RX: begin
          if (ready_q || full_q) begin
            stat.byte_dropped = 1'b1;
          end else begin
            mem_we = 1'b1;
            fill_d = CntW'(fill_inc);
            // Header positions never meet the total or the limit (both >= 6)
            if (fill_inc == TOTAL_W'(POS_START)) begin
              byte0_d = rx_byte;
            end else if (fill_inc == TOTAL_W'(POS_ADDR)) begin
              // Hunt: on mismatch the new byte becomes the first one
              if (byte0_q != start_q || rx_byte != addr_q) begin
                mem_waddr = '0;
                byte0_d   = rx_byte;
                fill_d    = CntW'(POS_START);
              end
            end else if (fill_inc == TOTAL_W'(POS_LEN_LO)) begin
              lenlo_d = rx_byte;
            end else if (fill_inc == TOTAL_W'(POS_LEN_HI)) begin
              len_d = {rx_byte, lenlo_q};
            end else if (fill_inc == total) begin
              ready_d = 1'b1;
            end else if (fill_inc >= eff_limit) begin
              full_d = 1'b1;
            end
          end
        end
        CMD_READ: begin
          mem_re            = 1'b1;
          stat.index_valid  = TOTAL_W'(read_index) < TOTAL_W'(fill_q);
        end
        CMD_RELEASE: begin
          if (TOTAL_W'(request_length) <= total) begin
            fill_d          = '0;
            ready_d         = 1'b0;
            full_d          = 1'b0;
            stat.release_ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
    total_nxt         = TOTAL_W'(len_d) + TOTAL_W'(HDR_CRC_BYTES);
    stat.frame_ready  = ready_d;
    stat.buffer_full  = full_d;
    stat.total_length = total_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
      addr_q  <= ADDR_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START:   start_q <= cfg_data_i[BYTE_W-1:0];
        CFG_ADDRESS: addr_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_LIMIT:   limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      len_q   <= '0;
      ready_q <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      len_q   <= len_d;
      ready_q <= ready_d;
      full_q  <= full_d;
    end
  end

  // Header bytes held for the hunt and the length
  always_ff @(posedge clk_i) begin
    byte0_q <= byte0_d;
    lenlo_q <= lenlo_d;
  end

  stu_frame_store #(
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx_byte),
    .re_i    (mem_re),
    .raddr_i (AddrW'(read_index)),
    .rdata_o (mem_rdata)
  );

  // Read stage: status waits beside the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= stat;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= {2'b00, s1_q.release_ok, s1_q.byte_dropped, s1_q.total_length,
                s1_q.buffer_full, s1_q.frame_ready, s1_q.index_valid,
                (s1_q.index_valid ? mem_rdata : BYTE_W'(0))};
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Checks
  `STU_ASSERT(a_fill_bound, fill_q <= CntW'(BUF_DEPTH), "fill count beyond store depth")
  `STU_ASSERT(a_flags_excl, !(ready_q && full_q), "ready and full set together")
  `STU_ASSERT(a_s1_hold, s1_valid_q && !s1_adv |=> s1_valid_q, "read stage lost a word")
  `STU_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_q && !s1_valid_q, "valid in reset")

endmodule

@@ dv/tb_scanner_telegram_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the scanner telegram receiver
// Streams received bytes, store reads and releases into the block, and holds
// a cycle-free mirror of the telegram store that predicts each status word.
// A short directed run covers the header hunt, ready, full, drops and release
// limits. Random runs follow under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_scanner_telegram_receiver_unit import stu_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // One pending input word
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic [IDX_W-1:0]  read_index;
    logic [REQ_W-1:0]  req_len;
    logic              hold;      // wait until every status word is back
  } stu_item_t;

  // Status word, laid out as on m_axis_tdata_o
  typedef struct packed {
    logic [1:0]         pad;
    logic               release_ok;
    logic               byte_dropped;
    logic [TOTAL_W-1:0] total_length;
    logic               buffer_full;
    logic               frame_ready;
    logic               index_valid;
    logic [BYTE_W-1:0]  read_data;
  } rx_status_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [S_TDATA_W-1:0]  s_data = '0;
  logic [CMD_W-1:0]      s_user = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [M_TDATA_W-1:0]  m_data;
  logic                  cfg_we = 1'b0;
  cfg_idx_e              cfg_idx = CFG_START;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stu_item_t   pending_words[$];
  rx_status_t  expected_status[$];
  bit          word_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned phase_words = 0;

  // Telegram store mirror
  logic [BYTE_W-1:0]  tg_store [BUF_DEPTH_DEF];
  int unsigned        tg_fill = 0;
  logic [LEN_W-1:0]   tg_len = '0;
  logic               tg_ready = 1'b0;
  logic               tg_full = 1'b0;
  logic [BYTE_W-1:0]  reg_start = START_RESET;
  logic [BYTE_W-1:0]  reg_addr = ADDR_RESET;
  logic [LIMIT_W-1:0] reg_limit = LIMIT_RESET;

  // Header values and clamped limit the stimulus builds telegrams from
  logic [BYTE_W-1:0]  frm_start = START_RESET;
  logic [BYTE_W-1:0]  frm_addr = ADDR_RESET;
  int unsigned        frm_lim = BUF_DEPTH_DEF;

  scanner_telegram_receiver_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Advance the store mirror by one word and return its status
  function automatic rx_status_t predict_status(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                                                logic [IDX_W-1:0] idx, logic [REQ_W-1:0] req);
    rx_status_t  st;
    int unsigned total;
    int unsigned lim;
    st = '0;
    total = tg_len + HDR_CRC_BYTES;
    lim = (reg_limit < MIN_LIMIT) ? MIN_LIMIT :
          (reg_limit > BUF_DEPTH_DEF) ? BUF_DEPTH_DEF : reg_limit;
    case (cmd)
      CMD_RX: begin
        if (tg_ready || tg_full) begin
          st.byte_dropped = 1'b1;
        end else begin
          if (tg_fill < BUF_DEPTH_DEF) tg_store[tg_fill] = b;
          tg_fill++;
          if (tg_fill == POS_ADDR) begin
            // shift the second byte down and keep hunting
            if (tg_store[0] != reg_start || tg_store[1] != reg_addr) begin
              tg_store[0] = tg_store[1];
              tg_fill = POS_START;
            end
          end else if (tg_fill == POS_LEN_HI) begin
            tg_len = {tg_store[3], tg_store[2]};
          end else if (tg_fill == total) begin
            tg_ready = 1'b1;
          end else if (tg_fill >= lim) begin
            tg_full = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (idx < tg_fill) begin
          st.read_data = tg_store[idx];
          st.index_valid = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (req <= total) begin
          tg_fill = 0;
          tg_ready = 1'b0;
          tg_full = 1'b0;
          st.release_ok = 1'b1;
        end
      end
      default: ;
    endcase
    st.frame_ready = tg_ready;
    st.buffer_full = tg_full;
    st.total_length = TOTAL_W'(tg_len) + TOTAL_W'(HDR_CRC_BYTES);
    return st;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Check status words, apply register writes, predict taken words
  always @(posedge clk_i) begin : watch_ports
    rx_status_t got;
    rx_status_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data;
      if (expected_status.size() == 0) begin
        $error("status word %h arrived with none expected", m_data);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("index_valid", want.index_valid, got.index_valid);
        compare_field("frame_ready", want.frame_ready, got.frame_ready);
        compare_field("buffer_full", want.buffer_full, got.buffer_full);
        compare_field("frame_total_length", want.total_length, got.total_length);
        compare_field("byte_dropped", want.byte_dropped, got.byte_dropped);
        compare_field("release_ok", want.release_ok, got.release_ok);
      end
    end
    if (rst_ni && cfg_we) begin
      case (cfg_idx)
        CFG_START:   reg_start = cfg_data[BYTE_W-1:0];
        CFG_ADDRESS: reg_addr = cfg_data[BYTE_W-1:0];
        CFG_LIMIT:   reg_limit = cfg_data;
        default: ;
      endcase
    end
    word_taken = rst_ni && s_valid && s_ready;
    if (word_taken)
      expected_status.push_back(predict_status(s_user, s_data[7:0], s_data[17:8],
                                               s_data[33:18]));
  end

  // Present the next word, idling at random or holding for a drain
  always @(negedge clk_i) begin : drive_words
    stu_item_t it;
    if (!s_valid || word_taken) begin
      if (rst_ni && pending_words.size() != 0 &&
          !(pending_words[0].hold && expected_status.size() != 0) &&
          $urandom_range(99) >= src_idle_pct) begin
        it = pending_words.pop_front();
        s_valid <= 1'b1;
        s_user <= it.cmd;
        s_data <= {6'd0, it.req_len, it.read_index, it.rx_byte};
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Stall the status stream at random
  always @(negedge clk_i) begin : drive_ready
    m_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic push_word(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx,
                           logic [REQ_W-1:0] req, bit hold = 1'b0);
    pending_words.push_back('{cmd: cmd, rx_byte: b, read_index: idx, req_len: req, hold: hold});
    phase_words++;
  endtask

  // Queue a telegram with the given length, cut or padded to nbytes
  task automatic queue_telegram(logic [LEN_W-1:0] len, int unsigned nbytes, bit hold);
    logic [BYTE_W-1:0] b;
    for (int unsigned i = 0; i < nbytes; i++) begin
      case (i)
        0: b = frm_start;
        1: b = frm_addr;
        2: b = len[7:0];
        3: b = len[15:8];
        default: b = 8'($urandom);
      endcase
      push_word(CMD_RX, b, 10'($urandom), 16'($urandom), hold && i == 0);
    end
  endtask

  task automatic write_regs(logic [BYTE_W-1:0] start, logic [BYTE_W-1:0] addr,
                            logic [LIMIT_W-1:0] limit);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_START;
    cfg_data <= CFG_DATA_W'(start);
    @(negedge clk_i);
    cfg_idx <= CFG_ADDRESS;
    cfg_data <= CFG_DATA_W'(addr);
    @(negedge clk_i);
    cfg_idx <= CFG_LIMIT;
    cfg_data <= limit;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    frm_start = start;
    frm_addr = addr;
    frm_lim = (limit < MIN_LIMIT) ? MIN_LIMIT : (limit > BUF_DEPTH_DEF) ? BUF_DEPTH_DEF : limit;
  endtask

  // Wait until no word is pending or in flight, then let the pipeline settle
  task automatic wait_quiet();
    while (pending_words.size() != 0 || s_valid || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
      default: begin src_idle_pct = 19; snk_stall_pct = 19; end
    endcase
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0]  len;
    logic [REQ_W-1:0]  rel_req;
    int unsigned       total;
    int unsigned       nbytes;
    bit                hold;
    bit                first;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset registers, empty store, hunt, ready, drops, release bounds
    push_word(CMD_READ, 8'h00, 10'd0, 16'h0000);
    push_word(CMD_SPARE, 8'hFF, 10'h3FF, 16'hFFFF);
    push_word(CMD_RELEASE, 8'h00, 10'd0, 16'hFFFF);
    push_word(CMD_RX, 8'h55, 10'd0, 16'h0000);
    queue_telegram(16'h0000, 6, 1'b0);
    push_word(CMD_RX, 8'hFF, 10'd0, 16'h0000);
    push_word(CMD_READ, 8'h00, 10'd0, 16'h0000);
    push_word(CMD_READ, 8'h00, 10'h3FF, 16'h0000);
    push_word(CMD_RELEASE, 8'h00, 10'd0, 16'd7);
    push_word(CMD_RELEASE, 8'h00, 10'd0, 16'd6);
    wait_quiet();

    // Directed: limit below minimum, ready against full at the limit
    write_regs(START_RESET, ADDR_RESET, 11'd0);
    queue_telegram(16'h0000, 6, 1'b0);
    push_word(CMD_RELEASE, 8'h00, 10'd0, 16'd0);
    queue_telegram(16'hFFFF, 6, 1'b0);
    push_word(CMD_READ, 8'h00, 10'd5, 16'h0000);
    push_word(CMD_RELEASE, 8'h00, 10'd0, 16'hFFFF);
    wait_quiet();

    // Random phases under rotating registers and idle mixes
    for (int p = 0; p < 10; p++) begin
      set_idling(p % 4);
      case (p)
        0: write_regs(START_RESET, ADDR_RESET, LIMIT_RESET);
        1: write_regs(8'h00, 8'hFF, 11'd7);
        2: write_regs(8'hFF, 8'h00, 11'h7FF);
        3: write_regs(8'h5A, 8'h5A, 11'd40);
        4: write_regs(8'($urandom), 8'($urandom), 11'd5);
        5: write_regs(8'($urandom), 8'($urandom), 11'd6);
        default: write_regs(8'($urandom), 8'($urandom),
                            $urandom_range(1) ? 11'($urandom_range(6, 64)) : 11'($urandom));
      endcase
      phase_words = 0;
      first = 1'b1;
      while (phase_words < 100) begin
        if ($urandom_range(99) < 15) begin
          // noise: any command with any content
          push_word(2'($urandom), 8'($urandom), 10'($urandom), 16'($urandom));
        end else begin
          hold = (p == 5 && first) || $urandom_range(39) == 0;
          first = 1'b0;
          repeat ($urandom_range(0, 1)) push_word(CMD_RX, 8'($urandom), 10'($urandom),
                                                  16'($urandom));
          if (frm_lim <= 64 && $urandom_range(3) == 0) len = 16'($urandom);
          else len = 16'($urandom_range(0, 24));
          total = len + HDR_CRC_BYTES;
          nbytes = (total > frm_lim) ? frm_lim + $urandom_range(0, 2) : total;
          if ($urandom_range(7) == 0) nbytes = $urandom_range(1, nbytes);
          queue_telegram(len, nbytes, hold);
          repeat ($urandom_range(1, 3))
            push_word(CMD_READ, 8'($urandom),
                      ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(0, nbytes)),
                      16'($urandom));
          if ($urandom_range(3) == 0)
            push_word(CMD_RX, 8'($urandom), 10'($urandom), 16'($urandom));
          if ($urandom_range(9) < 7)
            rel_req = 16'($urandom_range(0, (total > 16'hFFFF) ? 16'hFFFF : total));
          else
            rel_req = 16'($urandom);
          push_word(CMD_RELEASE, 8'($urandom), 10'($urandom), rel_req);
        end
      end
      wait_quiet();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_status.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #1ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
